[src/sitoa_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; imported by the digit cell, the digit chain and the top level.
package sitoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int STEP_CNT_W = 6;
  localparam int REM_W      = 4;

  localparam logic [STEP_CNT_W-1:0] DABBLE_STEPS = 6'd32;
  localparam logic [REM_W-1:0]      DIGITS_FULL  = 4'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } sitoa_state_t;

  // Control shared by every digit cell in the chain
  typedef struct packed {
    logic clr;     // zero the digit
    logic dabble;  // one shift-and-add-3 step
    logic emit;    // take the digit of the less significant neighbour
  } sitoa_cell_ctrl_t;

endpackage

[src/sitoa_bcd_cell.sv]
// One BCD digit cell: holds a decimal digit, performs a double-dabble step
// or moves its digit one place up. Depends on sitoa_pkg.
module sitoa_bcd_cell
  import sitoa_pkg::*;
(
  input  logic             clk,
  input  sitoa_cell_ctrl_t ctrl,
  input  logic             bit_in,
  input  logic [3:0]       digit_in,
  output logic             bit_out,
  output logic [3:0]       digit_q
);

  logic [3:0] digit_r, digit_nxt;
  logic [3:0] adj;

  // Add three when the digit is five or more, so the shift carries correctly
  assign adj     = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out = adj[3];
  assign digit_q = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.emit) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

[src/sitoa_bcd_chain.sv]
// Row of BCD digit cells, least significant first, for binary to decimal
// conversion and most-significant-first readout. Depends on sitoa_pkg, sitoa_bcd_cell.
module sitoa_bcd_chain
  import sitoa_pkg::*;
(
  input  logic             clk,
  input  sitoa_cell_ctrl_t ctrl,
  input  logic             bit_in,
  output logic [3:0]       top_digit
);

  logic [3:0] digit_q [NUM_DIGITS];
  logic       carry   [NUM_DIGITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic       cell_bit_in;
    logic [3:0] cell_digit_in;

    if (i == 0) begin : g_low
      assign cell_bit_in   = bit_in;
      assign cell_digit_in = 4'd0;
    end else begin : g_mid
      assign cell_bit_in   = carry[i-1];
      assign cell_digit_in = digit_q[i-1];
    end

    if (i < NUM_DIGITS-1) begin : g_carry
      sitoa_bcd_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (cell_bit_in),
        .digit_in (cell_digit_in),
        .bit_out  (carry[i]),
        .digit_q  (digit_q[i])
      );
    end else begin : g_top
      // The magnitude never exceeds ten digits, so the top carry is always clear
      sitoa_bcd_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (cell_bit_in),
        .digit_in (cell_digit_in),
        .bit_out  (),
        .digit_q  (digit_q[i])
      );
    end
  end

  assign top_digit = digit_q[NUM_DIGITS-1];

endmodule

[src/signed_int_to_decimal_ascii_unit.sv]
// Signed 32-bit integer to decimal ASCII text, one character per output beat.
// A new value is taken only in idle, after the last character of the previous
// value has been handed to the output register. Conversion is a 32-step
// double-dabble shift through the ten digit cells, after which leading zeros
// are dropped. Reset (rst_n, synchronous) returns to idle
// and drops any pending output beat. Depends on sitoa_pkg, sitoa_bcd_chain.
module signed_int_to_decimal_ascii_unit
  import sitoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_character,
  output logic               out_last_char
);

  sitoa_state_t state_r, state_nxt;

  // Magnitude shift register, sign flag and counters
  logic [VALUE_W-1:0]    mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [STEP_CNT_W-1:0] step_r, step_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;

  // Output register: parts the conversion from the consumer
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  sitoa_cell_ctrl_t cell_ctrl;
  logic [3:0]       top_digit;
  logic             in_fire;
  logic             slot_free;
  logic [VALUE_W-1:0] raw;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  // Output slot can take a new beat when empty or being drained this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign raw       = in_value;

  sitoa_bcd_chain u_chain (
    .clk       (clk),
    .ctrl      (cell_ctrl),
    .bit_in    (mag_r[VALUE_W-1]),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cell_ctrl     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // Take the magnitude as unsigned so the most negative value survives
          neg_nxt       = raw[VALUE_W-1];
          mag_nxt       = raw[VALUE_W-1] ? (~raw + 32'd1) : raw;
          step_nxt      = DABBLE_STEPS;
          cell_ctrl.clr = 1'b1;
          state_nxt     = ST_CONV;
        end
      end

      ST_CONV: begin
        // Shift one magnitude bit into the digit cells per cycle
        cell_ctrl.dabble = 1'b1;
        mag_nxt          = {mag_r[VALUE_W-2:0], 1'b0};
        step_nxt         = step_r - 6'd1;
        if (step_r == 6'd1) begin
          rem_nxt   = DIGITS_FULL;
          state_nxt = ST_SKIP;
        end
      end

      ST_SKIP: begin
        // Drop leading zeros, but always keep the final digit
        if ((top_digit == 4'd0) && (rem_r != 4'd1)) begin
          cell_ctrl.emit = 1'b1;
          rem_nxt        = rem_r - 4'd1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end

      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGITS;
        end
      end

      ST_DIGITS: begin
        // Hand the top digit to the output register and advance the chain
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = CHAR_ZERO + {4'd0, top_digit};
          out_last_nxt   = (rem_r == 4'd1);
          cell_ctrl.emit = 1'b1;
          rem_nxt        = rem_r - 4'd1;
          if (rem_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

endmodule
